// File: hdl/fps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_pkg: shared types and constants of the framed packet sender
// Command kinds, register indexes, frame layout and acknowledge pattern.
// ----------------------------------------------------------------------------
package fps_pkg;

    // Payload size and frame layout
    localparam int PAYLOAD_BYTES = 32;
    localparam int HEADER_BYTES  = 5;
    localparam int FRAME_LEN     = HEADER_BYTES + PAYLOAD_BYTES;
    localparam int POS_W         = $clog2(FRAME_LEN);
    localparam int PAY_IDX_W     = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int ATTEMPT_W  = 4;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Register reset values
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST  = 4'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd1500;

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE = 8'h50;
    localparam int         SYNC_LEN  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_HEADER  = 2'd1,
        CMD_PAYLOAD = 2'd2
    } t_command;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_ATTEMPTS  = 1'd0,
        CFG_TIMEOUT_TICKS = 1'd1
    } t_cfg_index;

    // Expected reply byte for each reply slot
    function automatic logic [7:0] ack_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hAA;
            2'd1:    b = 8'h05;
            2'd2:    b = 8'h00;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/framed_packet_sender_with_ack_retry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_sender_with_ack_retry: stop-and-wait sender with retry
// Loads a header and payload, waits for CTS, sends the frame byte by byte
// on ticks, checks a three-byte acknowledge and retries on failure.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                         tuser
//  s_axis    in         fn_code, packet_count, data_byte,          command
//                       cts_level, rx_valid, rx_byte, tx_ready
//  m_axis    out        tx_valid, tx_byte, rts_level, rx_flush,    -
//                       packet_done, packet_acked, attempts_used,
//                       busy_res
//  cfg       in         i_cfg_we / i_cfg_addr / i_cfg_data         -
//
//  One word in gives one word out. A word is taken every cycle except
//  while the skid entry is full, the only time s_axis_tready drops. The
//  state update is a single pass through the next-state logic. A two-entry
//  output (register plus skid) keeps input flowing while one result waits.
//  Synchronous active-low reset clears state, counters and registers; the
//  payload store has no reset and is always filled before it is read.
// ----------------------------------------------------------------------------
module framed_packet_sender_with_ack_retry (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // fn_code[7:0], packet_count[15:8], data_byte[23:16], cts_level[24],
    // rx_valid[25], rx_byte[33:26], tx_ready[34], zero pad[39:35]
    input  logic [fps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [fps_pkg::CMD_W-1:0]        s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tx_valid[0], tx_byte[8:1], rts_level[9], rx_flush[10], packet_done[11],
    // packet_acked[12], attempts_used[16:13], busy_res[17], zero pad[23:18]
    output logic [fps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_we,
    input  logic [fps_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOAD,
        PH_WAIT_CTS,
        PH_SEND,
        PH_REPLY
    } t_phase;

    localparam logic [fps_pkg::POS_W-1:0] LAST_PAY_POS =
        fps_pkg::POS_W'(fps_pkg::PAYLOAD_BYTES - 1);
    localparam logic [fps_pkg::POS_W-1:0] LAST_FRAME_POS =
        fps_pkg::POS_W'(fps_pkg::FRAME_LEN - 1);
    localparam logic [fps_pkg::POS_W-1:0] FN_POS   = fps_pkg::POS_W'(fps_pkg::SYNC_LEN);
    localparam logic [fps_pkg::POS_W-1:0] CNT_POS  = fps_pkg::POS_W'(fps_pkg::SYNC_LEN + 1);
    localparam logic [fps_pkg::POS_W-1:0] HDR_LEN  = fps_pkg::POS_W'(fps_pkg::HEADER_BYTES);

    // Input word fields
    logic                  in_accept;
    fps_pkg::t_command     cmd;
    logic [7:0]            in_fn_code;
    logic [7:0]            in_packet_count;
    logic [7:0]            in_data_byte;
    logic                  in_cts;
    logic                  in_rx_valid;
    logic [7:0]            in_rx_byte;
    logic                  in_tx_ready;

    // Configuration
    logic [fps_pkg::ATTEMPT_W-1:0] r_max_attempts;
    logic [fps_pkg::TIMEOUT_W-1:0] r_timeout_ticks;
    logic [fps_pkg::ATTEMPT_W-1:0] limit;

    // State
    t_phase                         r_phase,    n_phase;
    logic [7:0]                     r_fn_code,  n_fn_code;
    logic [7:0]                     r_counter,  n_counter;
    logic [fps_pkg::POS_W-1:0]      r_pos,      n_pos;
    logic [1:0]                     r_reply,    n_reply;
    logic                           r_mismatch, n_mismatch;
    logic [fps_pkg::TIMEOUT_W-1:0]  r_wait,     n_wait;
    logic [fps_pkg::ATTEMPT_W-1:0]  r_attempt,  n_attempt;
    logic [7:0]                     r_payload [fps_pkg::PAYLOAD_BYTES];

    // Per-word result flags
    logic                           pay_we;
    logic [fps_pkg::PAY_IDX_W-1:0]  pay_rd_idx;
    logic [fps_pkg::POS_W-1:0]      pay_off;
    logic [7:0]                     frame_byte;
    logic                           tx_valid;
    logic [7:0]                     tx_byte;
    logic                           flush;
    logic                           done;
    logic                           acked;
    logic                           failed;
    logic                           mism_next;
    logic [fps_pkg::OUT_DATA_W-1:0] result;

    // Output register and skid entry
    logic [fps_pkg::OUT_DATA_W-1:0] r_out_data, r_skid_data;
    logic                           r_out_valid, r_skid_valid;
    logic                           out_free;

    // Unpack input word
    assign in_accept       = s_axis_tvalid && s_axis_tready;
    assign cmd             = fps_pkg::t_command'(s_axis_tuser);
    assign in_fn_code      = s_axis_tdata[7:0];
    assign in_packet_count = s_axis_tdata[15:8];
    assign in_data_byte    = s_axis_tdata[23:16];
    assign in_cts          = s_axis_tdata[24];
    assign in_rx_valid     = s_axis_tdata[25];
    assign in_rx_byte      = s_axis_tdata[33:26];
    assign in_tx_ready     = s_axis_tdata[34];

    // Zero attempts behaves as one
    assign limit = (r_max_attempts == '0) ? fps_pkg::ATTEMPT_W'(1) : r_max_attempts;

    // Select the frame byte at the current position
    assign pay_off    = r_pos - HDR_LEN;
    assign pay_rd_idx = pay_off[fps_pkg::PAY_IDX_W-1:0];

    always_comb begin
        if (r_pos < FN_POS) begin
            frame_byte = fps_pkg::SYNC_BYTE;
        end else if (r_pos == FN_POS) begin
            frame_byte = r_fn_code;
        end else if (r_pos == CNT_POS) begin
            frame_byte = r_counter;
        end else begin
            frame_byte = r_payload[pay_rd_idx];
        end
    end

    assign mism_next = r_mismatch || (in_rx_byte != fps_pkg::ack_byte(r_reply));

    // Next-state logic for one word
    always_comb begin
        n_phase    = r_phase;
        n_fn_code  = r_fn_code;
        n_counter  = r_counter;
        n_pos      = r_pos;
        n_reply    = r_reply;
        n_mismatch = r_mismatch;
        n_wait     = r_wait;
        n_attempt  = r_attempt;
        pay_we     = 1'b0;
        tx_valid   = 1'b0;
        tx_byte    = 8'h00;
        flush      = 1'b0;
        done       = 1'b0;
        acked      = 1'b0;
        failed     = 1'b0;

        case (cmd)
            fps_pkg::CMD_HEADER: begin
                if (r_phase == PH_IDLE) begin
                    n_fn_code = in_fn_code;
                    n_counter = in_packet_count;
                    n_pos     = '0;
                    n_attempt = '0;
                    n_phase   = PH_LOAD;
                end
            end
            fps_pkg::CMD_PAYLOAD: begin
                if (r_phase == PH_LOAD) begin
                    pay_we = 1'b1;
                    if (r_pos == LAST_PAY_POS) begin
                        n_pos   = '0;
                        n_phase = PH_WAIT_CTS;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            fps_pkg::CMD_TICK: begin
                case (r_phase)
                    PH_WAIT_CTS: begin
                        if (in_cts) begin
                            flush     = 1'b1;
                            n_attempt = r_attempt + 1'b1;
                            n_pos     = '0;
                            n_phase   = PH_SEND;
                        end
                    end
                    PH_SEND: begin
                        if (in_tx_ready) begin
                            tx_valid = 1'b1;
                            tx_byte  = frame_byte;
                            if (r_pos == LAST_FRAME_POS) begin
                                n_pos      = '0;
                                n_reply    = '0;
                                n_mismatch = 1'b0;
                                n_wait     = '0;
                                n_phase    = PH_REPLY;
                            end else begin
                                n_pos = r_pos + 1'b1;
                            end
                        end
                    end
                    PH_REPLY: begin
                        // Collect reply bytes, judge after the third
                        if (in_rx_valid) begin
                            n_wait = '0;
                            if (r_reply == 2'd2) begin
                                n_reply    = '0;
                                n_mismatch = mism_next;
                                if (!mism_next) begin
                                    done  = 1'b1;
                                    acked = 1'b1;
                                end else begin
                                    failed = 1'b1;
                                end
                            end else begin
                                n_reply    = r_reply + 1'b1;
                                n_mismatch = mism_next;
                            end
                        end else if (r_wait >= r_timeout_ticks) begin
                            failed = 1'b1;
                        end else begin
                            n_wait = r_wait + 1'b1;
                        end
                        // Retry or give up
                        if (failed) begin
                            n_reply    = '0;
                            n_mismatch = 1'b0;
                            n_wait     = '0;
                            if (r_attempt >= limit) begin
                                done = 1'b1;
                            end else begin
                                flush     = 1'b1;
                                n_attempt = r_attempt + 1'b1;
                                n_pos     = '0;
                                n_phase   = PH_SEND;
                            end
                        end
                        if (done) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Pack result word from the state after this word
    assign result = {
        6'd0,
        (n_phase != PH_IDLE),
        n_attempt,
        acked,
        done,
        flush,
        (n_phase == PH_WAIT_CTS || n_phase == PH_SEND || n_phase == PH_REPLY),
        tx_byte,
        tx_valid
    };

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_attempts  <= fps_pkg::MAX_ATTEMPTS_RST;
            r_timeout_ticks <= fps_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (fps_pkg::t_cfg_index'(i_cfg_addr))
                fps_pkg::CFG_MAX_ATTEMPTS:
                    r_max_attempts <= i_cfg_data[fps_pkg::ATTEMPT_W-1:0];
                fps_pkg::CFG_TIMEOUT_TICKS:
                    r_timeout_ticks <= i_cfg_data[fps_pkg::TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold state, advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_fn_code  <= '0;
            r_counter  <= '0;
            r_pos      <= '0;
            r_reply    <= '0;
            r_mismatch <= 1'b0;
            r_wait     <= '0;
            r_attempt  <= '0;
        end else if (in_accept) begin
            r_phase    <= n_phase;
            r_fn_code  <= n_fn_code;
            r_counter  <= n_counter;
            r_pos      <= n_pos;
            r_reply    <= n_reply;
            r_mismatch <= n_mismatch;
            r_wait     <= n_wait;
            r_attempt  <= n_attempt;
        end
    end

    // Payload store, written in load order
    always_ff @(posedge i_clk) begin
        if (in_accept && pay_we) begin
            r_payload[r_pos[fps_pkg::PAY_IDX_W-1:0]] <= in_data_byte;
        end
    end

    // Output register with skid entry
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else if (in_accept) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= result;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= result;
            end
        end
    end

endmodule

// File: hdl/fps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fps_checker: port-level checks of the framed packet sender
// Watches the output stream for consistent status words.
// ----------------------------------------------------------------------------
module fps_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [fps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Acknowledge only with release
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11])
        else $error("packet_acked without packet_done");

    // Released packet drops busy and RTS, after at least one send
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |->
            !m_axis_tdata[17] && !m_axis_tdata[9] && (m_axis_tdata[16:13] != 4'd0))
        else $error("packet_done with busy, RTS or no send");

    // A frame byte goes out only under RTS, and no byte value without it
    a_tx_rts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9] && m_axis_tdata[17])
        else $error("tx byte sent without RTS");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[8:1] == 8'h00))
        else $error("tx byte nonzero without tx_valid");

endmodule

bind framed_packet_sender_with_ack_retry fps_checker u_fps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
